// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and geometry helpers for the text console window writer.
// Used by every module in rtl/core.
package tcw_pkg;

    localparam int ROWS       = 25;
    localparam int ROW_BYTES  = 160;
    localparam int HALF_BYTES = 80;
    localparam int ROW_CELLS  = ROW_BYTES / 2;
    localparam int CELLS      = ROWS * ROW_CELLS;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int ROW_W      = $clog2(ROWS + 1);
    localparam int COL_W      = $clog2(ROW_BYTES + 1);
    localparam int CURSOR_W   = 12;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] NORMAL_COLOR_RST = 8'd7;
    localparam logic [7:0] ERROR_COLOR_RST  = 8'd4;

    localparam logic CFG_NORMAL_COLOR = 1'b0;
    localparam logic CFG_ERROR_COLOR  = 1'b1;

    localparam logic [1:0] CMD_PUT_CHAR  = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_READ_CELL = 2'd2;

    localparam logic [1:0] WIN_FULL  = 2'd0;
    localparam logic [1:0] WIN_LEFT  = 2'd1;
    localparam logic [1:0] WIN_RIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [1:0]        window;
        logic              is_error;
        logic [7:0]        char_code;
        logic [CELL_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [7:0]          read_char;
        logic [7:0]          read_attr;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_PUT_CHAR,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        win;
        logic [7:0]        color;
        logic [7:0]        char_code;
        logic [CELL_W-1:0] cell_index;
    } task_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } cursor_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_BLANK,
        ST_APPLY,
        ST_CLR,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

    function automatic logic [COL_W-1:0] win_start(input logic [1:0] win);
        return (win == WIN_RIGHT) ? COL_W'(HALF_BYTES) : '0;
    endfunction

    function automatic logic [COL_W-1:0] win_end(input logic [1:0] win);
        return (win == WIN_LEFT) ? COL_W'(HALF_BYTES) : COL_W'(ROW_BYTES);
    endfunction

    function automatic logic [CURSOR_W-1:0] cur_offset(input cursor_t c);
        return CURSOR_W'(c.row) * CURSOR_W'(ROW_BYTES) + CURSOR_W'(c.col);
    endfunction

    function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return CELL_W'(row) * CELL_W'(ROW_CELLS) + CELL_W'(col >> 1);
    endfunction

endpackage

// ===== rtl/core/tcw_front.sv =====
`timescale 1ns / 1ps
// Front end: takes requests, folds the window code, resolves color and
// splits put_char into print, newline and backspace tasks. Uses tcw_pkg.
module tcw_front (
    input  logic              in_valid,
    output logic              in_ready,
    input  tcw_pkg::in_item_t in_data,
    input  logic [7:0]        normal_color,
    input  logic [7:0]        error_color,
    input  logic              init_busy,
    input  logic              q_full,
    output logic              push,
    output tcw_pkg::task_t    push_task
);
    import tcw_pkg::*;

    logic [1:0] win;

    assign in_ready = !q_full && !init_busy;
    assign push     = in_valid && in_ready;
    assign win      = (in_data.window == WIN_LEFT || in_data.window == WIN_RIGHT)
                      ? in_data.window : WIN_FULL;

    always_comb
    begin
        push_task.win        = win;
        push_task.color      = in_data.is_error ? error_color : normal_color;
        push_task.char_code  = in_data.char_code;
        push_task.cell_index = in_data.cell_index;
        case (in_data.command)
            CMD_PUT_CHAR:
            begin
                if (in_data.char_code == CH_NEWLINE)
                    push_task.op = OP_NEWLINE;
                else if (in_data.char_code == CH_BACKSPACE)
                    push_task.op = OP_BACKSPACE;
                else
                    push_task.op = OP_PUT_CHAR;
            end
            CMD_CLEAR:     push_task.op = OP_CLEAR;
            CMD_READ_CELL: push_task.op = (32'(in_data.cell_index) < CELLS) ? OP_READ : OP_NOP;
            default:       push_task.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/tcw_queue.sv =====
`timescale 1ns / 1ps
// Short task queue between front and back end.
// Uses tcw_pkg.
module tcw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tcw_pkg::task_t push_task,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output tcw_pkg::task_t q_task
);
    import tcw_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    task_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full    = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_task  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_task;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/tcw_back.sv =====
`timescale 1ns / 1ps
// Back end: screen memory, window cursors, scroll/clear sweeps and the
// result register. Uses tcw_pkg.
module tcw_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tcw_pkg::task_t      q_task,
    output logic                pop,
    input  logic [7:0]          normal_color,
    output logic                init_busy,
    output logic                out_valid,
    input  logic                out_ready,
    output tcw_pkg::out_item_t  out_data
);
    import tcw_pkg::*;

    state_t            state_reg;
    state_t            state_next;

    logic [7:0]        chars_mem [CELLS];
    logic [7:0]        attrs_mem [CELLS];
    logic [7:0]        rd_char_reg;
    logic [7:0]        rd_attr_reg;

    task_t             task_reg;
    cursor_t           full_cur_reg;
    cursor_t           left_cur_reg;
    cursor_t           right_cur_reg;
    cursor_t           wcur_reg;
    logic [ROW_W-1:0]  srow_reg;
    logic [COL_W-1:0]  scol_reg;
    logic [CELL_W-1:0] init_addr_reg;
    logic [7:0]        res_char_reg;
    logic [7:0]        res_attr_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [COL_W-1:0]  w_start;
    logic [COL_W-1:0]  w_end;
    logic [COL_W-1:0]  scol_inc;
    logic              row_end;
    cursor_t           sel_cur;
    cursor_t           new_cur;
    logic              bs_skip;
    logic              need_scroll;
    logic              out_free;

    logic              we_c;
    logic              we_a;
    logic [CELL_W-1:0] wa;
    logic [7:0]        wd_c;
    logic [7:0]        wd_a;
    logic [CELL_W-1:0] ra;

    assign init_busy = (state_reg == ST_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign w_start  = win_start(task_reg.win);
    assign w_end    = win_end(task_reg.win);
    assign scol_inc = scol_reg + COL_W'(2);
    assign row_end  = (scol_inc == w_end);

    always_comb
    begin
        case (task_reg.win)
            WIN_LEFT:  sel_cur = left_cur_reg;
            WIN_RIGHT: sel_cur = right_cur_reg;
            default:   sel_cur = full_cur_reg;
        endcase
    end

    assign need_scroll = cur_offset(sel_cur) >=
                         CURSOR_W'((ROWS - 1) * ROW_BYTES) + CURSOR_W'(w_end);
    assign bs_skip     = (wcur_reg.row == '0) &&
                         (wcur_reg.col == w_start || wcur_reg.col < COL_W'(2));

    always_comb
    begin
        new_cur = wcur_reg;
        case (task_reg.op)
            OP_NEWLINE:
            begin
                new_cur.row = wcur_reg.row + 1'b1;
                new_cur.col = w_start;
            end
            OP_BACKSPACE:
            begin
                if (!bs_skip)
                begin
                    if (wcur_reg.col == w_start)
                    begin
                        new_cur.row = wcur_reg.row - 1'b1;
                        new_cur.col = w_end - COL_W'(2);
                    end
                    else
                        new_cur.col = wcur_reg.col - COL_W'(2);
                end
            end
            OP_PUT_CHAR:
            begin
                if (wcur_reg.col + COL_W'(2) == w_end)
                begin
                    new_cur.row = wcur_reg.row + 1'b1;
                    new_cur.col = w_start;
                end
                else
                    new_cur.col = wcur_reg.col + COL_W'(2);
            end
            default: new_cur = wcur_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
                if (32'(init_addr_reg) == CELLS - 1)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (task_reg.op)
                    OP_PUT_CHAR, OP_NEWLINE, OP_BACKSPACE:
                        state_next = need_scroll ? ST_SCR_RD : ST_APPLY;
                    OP_CLEAR: state_next = ST_CLR;
                    OP_READ:  state_next = ST_READ_WAIT;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_SCR_RD: state_next = ST_SCR_WR;
            ST_SCR_WR:
                if (row_end && 32'(srow_reg) == ROWS - 2)
                    state_next = ST_SCR_BLANK;
                else
                    state_next = ST_SCR_RD;
            ST_SCR_BLANK:
                if (row_end)
                    state_next = ST_APPLY;
            ST_APPLY: state_next = ST_RESULT;
            ST_CLR:
                if (row_end && 32'(srow_reg) == ROWS - 1)
                    state_next = ST_RESULT;
            ST_READ_WAIT: state_next = ST_RESULT;
            ST_RESULT:
                if (out_free)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        we_c = 1'b0;
        we_a = 1'b0;
        wa   = cell_addr(srow_reg, scol_reg);
        wd_c = CH_SPACE;
        wd_a = normal_color;
        ra   = cell_addr(srow_reg + 1'b1, scol_reg);
        case (state_reg)
            ST_INIT:
            begin
                we_c = 1'b1;
                we_a = 1'b1;
                wa   = init_addr_reg;
                wd_a = NORMAL_COLOR_RST;
            end
            ST_IDLE: pop = q_valid;
            ST_EXEC: ra = task_reg.cell_index;
            ST_SCR_WR:
            begin
                we_c = 1'b1;
                we_a = 1'b1;
                wd_c = rd_char_reg;
                wd_a = rd_attr_reg;
            end
            ST_SCR_BLANK: we_c = 1'b1;
            ST_CLR:
            begin
                we_c = 1'b1;
                we_a = 1'b1;
            end
            ST_APPLY:
            begin
                if (task_reg.op == OP_PUT_CHAR)
                begin
                    we_c = 1'b1;
                    we_a = 1'b1;
                    wa   = cell_addr(wcur_reg.row, wcur_reg.col);
                    wd_c = task_reg.char_code;
                    wd_a = task_reg.color;
                end
                else if (task_reg.op == OP_BACKSPACE && !bs_skip)
                begin
                    we_c = 1'b1;
                    wa   = cell_addr(new_cur.row, new_cur.col);
                end
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_c)
            chars_mem[wa] <= wd_c;
        if (we_a)
            attrs_mem[wa] <= wd_a;
        rd_char_reg <= chars_mem[ra];
        rd_attr_reg <= attrs_mem[ra];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                if (q_valid)
                    task_reg <= q_task;
            ST_EXEC:
            begin
                wcur_reg     <= sel_cur;
                srow_reg     <= '0;
                scol_reg     <= w_start;
                res_char_reg <= '0;
                res_attr_reg <= '0;
            end
            ST_SCR_WR:
            begin
                if (row_end)
                begin
                    srow_reg <= srow_reg + 1'b1;
                    scol_reg <= w_start;
                end
                else
                    scol_reg <= scol_inc;
            end
            ST_SCR_BLANK:
            begin
                scol_reg <= scol_inc;
                if (row_end)
                begin
                    wcur_reg.row <= ROW_W'(ROWS - 1);
                    wcur_reg.col <= w_start;
                end
            end
            ST_CLR:
            begin
                if (row_end)
                begin
                    srow_reg <= srow_reg + 1'b1;
                    scol_reg <= w_start;
                end
                else
                    scol_reg <= scol_inc;
            end
            ST_READ_WAIT:
            begin
                res_char_reg <= rd_char_reg;
                res_attr_reg <= rd_attr_reg;
            end
            default: res_char_reg <= res_char_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            full_cur_reg  <= '0;
            left_cur_reg  <= '0;
            right_cur_reg <= '{row: '0, col: COL_W'(HALF_BYTES)};
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
                init_addr_reg <= init_addr_reg + 1'b1;
            if (state_reg == ST_APPLY)
            begin
                case (task_reg.win)
                    WIN_LEFT:
                    begin
                        left_cur_reg <= new_cur;
                        full_cur_reg <= '0;
                    end
                    WIN_RIGHT:
                    begin
                        right_cur_reg <= new_cur;
                        full_cur_reg  <= '0;
                    end
                    default:
                    begin
                        full_cur_reg  <= new_cur;
                        left_cur_reg  <= '0;
                        right_cur_reg <= '{row: '0, col: COL_W'(HALF_BYTES)};
                    end
                endcase
            end
            if (state_reg == ST_CLR && row_end && 32'(srow_reg) == ROWS - 1)
            begin
                full_cur_reg <= '0;
                if (task_reg.win != WIN_RIGHT)
                    left_cur_reg <= '0;
                if (task_reg.win != WIN_LEFT)
                    right_cur_reg <= '{row: '0, col: COL_W'(HALF_BYTES)};
            end
            if (state_reg == ST_RESULT && out_free)
            begin
                out_valid_reg          <= 1'b1;
                out_data_reg.cursor    <= cur_offset(sel_cur);
                out_data_reg.read_char <= res_char_reg;
                out_data_reg.read_attr <= res_attr_reg;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/text_console_window_writer.sv =====
`timescale 1ns / 1ps
// Text console window writer top level. Print, newline and backspace pass from
// execute through apply to the result register, a read through execute and read
// wait; a scroll first copies the window up a row and blanks its bottom row, and
// a clear sweeps every window row. One item is worked at a time by the back-end
// sequencer and its memory port. Reset: cursors reset at once; a clearing pass
// keeps in_ready low.
module text_console_window_writer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tcw_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tcw_pkg::out_item_t  out_data,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);
    import tcw_pkg::*;

    logic [7:0] normal_color_reg;
    logic [7:0] error_color_reg;
    logic       init_busy;
    logic       q_full;
    logic       push;
    task_t      push_task;
    logic       pop;
    logic       q_valid;
    task_t      q_task;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_color_reg <= NORMAL_COLOR_RST;
            error_color_reg  <= ERROR_COLOR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_COLOR: normal_color_reg <= cfg_data;
                CFG_ERROR_COLOR:  error_color_reg  <= cfg_data;
                default:          normal_color_reg <= normal_color_reg;
            endcase
        end
    end

    tcw_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .normal_color (normal_color_reg),
        .error_color  (error_color_reg),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .push         (push),
        .push_task    (push_task)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_task    (q_task)
    );

    tcw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_task       (q_task),
        .pop          (pop),
        .normal_color (normal_color_reg),
        .init_busy    (init_busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

endmodule

// ===== test/text_console_window_writer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_window_writer: a screen model in a
// scoreboard class predicts every result; plain tasks drive requests and colors.
// Depends on tcw_pkg and the text_console_window_writer RTL.
module text_console_window_writer_test;
    import tcw_pkg::*;

    localparam logic [1:0] WIN_ALIAS = 2'd3;
    localparam logic [1:0] CMD_NONE  = 2'd3;
    localparam int SCREEN_BYTES = ROWS * ROW_BYTES;

    class console_board;
        logic [7:0] chars [CELLS];
        logic [7:0] attrs [CELLS];
        int cur_full, cur_left, cur_right;
        logic [7:0] normal_color, error_color;
        out_item_t expected_q[$];
        int errors;

        function new();
            for (int k = 0; k < CELLS; k++)
            begin
                chars[k] = CH_SPACE;
                attrs[k] = NORMAL_COLOR_RST;
            end
            cur_full = 0;
            cur_left = 0;
            cur_right = HALF_BYTES;
            normal_color = NORMAL_COLOR_RST;
            error_color = ERROR_COLOR_RST;
            errors = 0;
        endfunction

        function void set_color(logic idx, logic [7:0] v);
            if (idx == CFG_NORMAL_COLOR) normal_color = v;
            else error_color = v;
        endfunction

        function void put_byte(int b, logic [7:0] v);
            if (b >= SCREEN_BYTES) return;
            if (b % 2) attrs[b / 2] = v;
            else chars[b / 2] = v;
        endfunction

        function logic [7:0] get_byte(int b);
            if (b >= SCREEN_BYTES) return 8'd0;
            return (b % 2) ? attrs[b / 2] : chars[b / 2];
        endfunction

        function void geom(logic [1:0] w, output int start, output int len, output int step);
            if (w == WIN_LEFT)
            begin
                start = 0; len = HALF_BYTES; step = HALF_BYTES;
            end
            else if (w == WIN_RIGHT)
            begin
                start = HALF_BYTES; len = HALF_BYTES; step = HALF_BYTES;
            end
            else
            begin
                start = 0; len = ROW_BYTES; step = 0;
            end
        endfunction

        function int cursor_of(logic [1:0] w);
            if (w == WIN_LEFT) return cur_left;
            if (w == WIN_RIGHT) return cur_right;
            return cur_full;
        endfunction

        function void print_char(logic [1:0] w, logic [7:0] c, logic [7:0] color);
            int start, len, step, off, i, j, col;
            geom(w, start, len, step);
            off = cursor_of(w);
            if (off >= (ROWS - 1) * ROW_BYTES + len + start)
            begin
                i = start;
                j = ROW_BYTES + start;
                while (j < SCREEN_BYTES)
                begin
                    put_byte(i, get_byte(j));
                    i++;
                    j++;
                    if (i % len == 0)
                    begin
                        i += step;
                        j += step;
                    end
                end
                for (int k = (ROWS - 1) * ROW_BYTES + start;
                     k < (ROWS - 1) * ROW_BYTES + start + len; k += 2)
                    put_byte(k, CH_SPACE);
                off = (ROWS - 1) * ROW_BYTES + start;
            end
            if (c == CH_NEWLINE)
                off += (len - off % len) + step;
            else if (c == CH_BACKSPACE)
            begin
                if (off != start && off >= 2)
                begin
                    col = (off - 2) % ROW_BYTES;
                    if ((col < start || col >= start + len) && off >= step + 2) off -= step;
                    off -= 2;
                    put_byte(off, CH_SPACE);
                end
            end
            else
            begin
                put_byte(off, c);
                put_byte(off + 1, color);
                off += 2;
                if (off % len == 0) off += step;
            end
            if (w == WIN_LEFT) cur_left = off;
            else if (w == WIN_RIGHT) cur_right = off;
            else cur_full = off;
            if (w == WIN_LEFT || w == WIN_RIGHT)
                cur_full = 0;
            else
            begin
                cur_left = 0;
                cur_right = HALF_BYTES;
            end
        endfunction

        function void note(in_item_t it);
            out_item_t r;
            logic [1:0] w;
            int start, len, step, i;
            w = (it.window == WIN_ALIAS) ? WIN_FULL : it.window;
            r = '0;
            if (it.command == CMD_PUT_CHAR)
                print_char(w, it.char_code, it.is_error ? error_color : normal_color);
            else if (it.command == CMD_CLEAR)
            begin
                geom(w, start, len, step);
                cur_full = 0;
                if (w != WIN_RIGHT) cur_left = 0;
                if (w != WIN_LEFT) cur_right = HALF_BYTES;
                i = start;
                while (i < SCREEN_BYTES)
                begin
                    put_byte(i, CH_SPACE);
                    put_byte(i + 1, normal_color);
                    i += 2;
                    if (i % len == 0) i += step;
                end
            end
            else if (it.command == CMD_READ_CELL)
            begin
                if (it.cell_index < CELLS)
                begin
                    r.read_char = chars[it.cell_index];
                    r.read_attr = attrs[it.cell_index];
                end
            end
            r.cursor = CURSOR_W'(cursor_of(w) % 4096);
            expected_q.push_back(r);
        endfunction

        function void check(out_item_t got);
            out_item_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result cursor=%0d", got.cursor);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.cursor !== e.cursor)
            begin
                $error("cursor expected %0d actual %0d", e.cursor, got.cursor);
                errors++;
            end
            if (got.read_char !== e.read_char)
            begin
                $error("read_char expected %0d actual %0d", e.read_char, got.read_char);
                errors++;
            end
            if (got.read_attr !== e.read_attr)
            begin
                $error("read_attr expected %0d actual %0d", e.read_attr, got.read_attr);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [7:0] cfg_data = '0;

    console_board board = new();
    int sent = 0;

    text_console_window_writer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(in_item_t it);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        forever
        begin
            @(negedge clk);
            if (in_ready)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        board.note(it);
        sent++;
    endtask

    task automatic write_color(logic idx, logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_color(idx, v);
    endtask

    task automatic wait_drained();
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic in_item_t make_request(logic [1:0] cmd, logic [1:0] w,
                                              logic [7:0] c, logic [10:0] idx);
        in_item_t it;
        it.command = cmd;
        it.window = w;
        it.is_error = 1'($urandom_range(0, 1));
        it.char_code = c;
        it.cell_index = idx;
        return it;
    endfunction

    function automatic in_item_t random_request(logic [1:0] w);
        int pick;
        logic [1:0] cmd;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 72) cmd = CMD_PUT_CHAR;
        else if (pick < 74) cmd = CMD_CLEAR;
        else if (pick < 97) cmd = CMD_READ_CELL;
        else cmd = CMD_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 15) c = CH_NEWLINE;
        else if (pick < 25) c = CH_BACKSPACE;
        else c = 8'($urandom_range(0, 255));
        return make_request(cmd, w, c, 11'($urandom_range(0, 2047)));
    endfunction

    always
    begin
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            out_ready <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        forever
        begin
            @(negedge clk);
            if (out_valid)
            begin
                board.check(out_data);
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        #(200_000_000);
        $display("text_console_window_writer_test NOT OK");
        $finish;
    end

    initial
    begin
        logic [1:0] w;
        int burst;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, each window and command, edge reads
        send_request(make_request(CMD_PUT_CHAR, WIN_LEFT, CH_BACKSPACE, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_RIGHT, CH_BACKSPACE, 11'd2047));
        send_request(make_request(CMD_PUT_CHAR, WIN_FULL, CH_BACKSPACE, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_FULL, 8'd0, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_FULL, 8'd255, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_FULL, CH_BACKSPACE, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_ALIAS, CH_NEWLINE, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_LEFT, 8'd65, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_RIGHT, 8'd66, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_RIGHT, CH_NEWLINE, 11'd0));
        send_request(make_request(CMD_PUT_CHAR, WIN_RIGHT, CH_BACKSPACE, 11'd0));
        send_request(make_request(CMD_READ_CELL, WIN_FULL, 8'd0, 11'd0));
        send_request(make_request(CMD_READ_CELL, WIN_LEFT, 8'd0, 11'd40));
        send_request(make_request(CMD_READ_CELL, WIN_RIGHT, 8'd0, 11'd1999));
        send_request(make_request(CMD_READ_CELL, WIN_ALIAS, 8'd0, 11'd2000));
        send_request(make_request(CMD_READ_CELL, WIN_FULL, 8'd0, 11'd2047));
        send_request(make_request(CMD_NONE, WIN_RIGHT, 8'd255, 11'd2047));
        send_request(make_request(CMD_CLEAR, WIN_LEFT, 8'd0, 11'd0));
        send_request(make_request(CMD_CLEAR, WIN_RIGHT, 8'd0, 11'd0));
        send_request(make_request(CMD_CLEAR, WIN_ALIAS, 8'd0, 11'd0));
        send_request(make_request(CMD_READ_CELL, WIN_FULL, 8'd0, 11'd1999));

        // random phases; bursts on one window let its cursor reach the bottom
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                in_valid <= 1'b0;
                wait_drained();
                case (phase)
                    1:
                    begin
                        write_color(CFG_NORMAL_COLOR, 8'd0);
                        write_color(CFG_ERROR_COLOR, 8'd255);
                    end
                    2:
                    begin
                        write_color(CFG_NORMAL_COLOR, 8'd255);
                        write_color(CFG_ERROR_COLOR, 8'd0);
                    end
                    default:
                    begin
                        write_color(CFG_NORMAL_COLOR, 8'($urandom_range(0, 255)));
                        write_color(CFG_ERROR_COLOR, 8'($urandom_range(0, 255)));
                    end
                endcase
            end
            for (int n = 0; n < 375; )
            begin
                w = 2'($urandom_range(0, 3));
                burst = $urandom_range(5, 60);
                for (int b = 0; b < burst && n < 375; b++, n++)
                    send_request(($urandom_range(0, 9) == 0) ?
                                 random_request(2'($urandom_range(0, 3))) :
                                 random_request(w));
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (4100) @(posedge clk);

        $display("Run covered %0d requests over four color settings.", sent);
        if (board.errors == 0 && board.expected_q.size() == 0)
            $display("text_console_window_writer_test OK");
        else
            $display("text_console_window_writer_test NOT OK");
        $finish;
    end
endmodule

// ===== text_console_window_writer.f =====
rtl/core/tcw_pkg.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_window_writer.sv
test/text_console_window_writer_test.sv
